// ===== src/mtep_pkg.sv =====
// Shared types and constants for the MIDI track event parser.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none

package mtep_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // Register word index (paddr[3:2])
  localparam logic [1:0] REG_TRACK_LENGTH  = 2'd0;
  localparam logic [1:0] REG_SYSEX_MAX_LEN = 2'd1;
  localparam logic [1:0] REG_META_KEEP_LEN = 2'd2;

  localparam logic [31:0] TRACK_LENGTH_RST  = 32'd0;
  localparam logic [15:0] SYSEX_MAX_LEN_RST = 16'd256;
  localparam logic [7:0]  META_KEEP_LEN_RST = 8'd15;

  // Status and meta type bytes
  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_SYSEX_CONT = 8'hF7;
  localparam logic [7:0] ST_META       = 8'hFF;
  localparam logic [7:0] META_EOT      = 8'h2F;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] META_TIMESIG  = 8'h58;

  // Input item kind
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [2:0] {
    EVT_CHANNEL = 3'd0,
    EVT_SYSEX   = 3'd1,
    EVT_META    = 3'd2,
    EVT_TEMPO   = 3'd3,
    EVT_TIMESIG = 3'd4,
    EVT_END     = 3'd5,
    EVT_ABORT   = 3'd6
  } evt_kind_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    evt_kind_e   event_kind;
    logic [31:0] delta_ticks;
    logic [7:0]  status;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [1:0]  msg_bytes;
    logic [7:0]  meta_id;
    logic [31:0] meta_length;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        last;
    logic [23:0] tempo_us;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/mtep_in_if.sv =====
// Track byte channel: valid/ready handshake plus one input item.
// Depends on mtep_pkg.
`default_nettype none

interface mtep_in_if
  import mtep_pkg::*;
();
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;

  modport source (output valid, kind, byte_value, input ready);
  modport sink   (input valid, kind, byte_value, output ready);
endinterface

`default_nettype wire

// ===== src/mtep_out_if.sv =====
// Decoded event channel: valid/ready handshake plus one result item.
// Depends on mtep_pkg.
`default_nettype none

interface mtep_out_if
  import mtep_pkg::*;
();
  logic        valid;
  logic        ready;
  evt_kind_e   event_kind;
  logic [31:0] delta_ticks;
  logic [7:0]  status;
  logic [7:0]  data1;
  logic [7:0]  data2;
  logic [1:0]  msg_bytes;
  logic [7:0]  meta_id;
  logic [31:0] meta_length;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        last;
  logic [23:0] tempo_us;

  modport source (output valid, event_kind, delta_ticks, status, data1, data2, msg_bytes,
                  meta_id, meta_length, payload_byte, payload_valid, last, tempo_us,
                  input ready);
  modport sink   (input valid, event_kind, delta_ticks, status, data1, data2, msg_bytes,
                  meta_id, meta_length, payload_byte, payload_valid, last, tempo_us,
                  output ready);
endinterface

`default_nettype wire

// ===== src/midi_track_event_parser.sv =====
// MIDI track event parser: one track byte in, at most one decoded event out.
// A transferred byte is held in the input register; decode then writes the result
// register. Throughput: one byte per cycle, sustained, as long as the result side
// takes transfers.
// Reset: all parse state cleared, registers to defaults (track 0, sysex 256, keep 15).
// Depends on mtep_pkg, mtep_in_if, mtep_out_if.
`default_nettype none

module midi_track_event_parser
  import mtep_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  mtep_in_if.sink                    byte_i,
  mtep_out_if.source                 event_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  // Parse phases
  localparam logic [3:0] PH_DELTA   = 4'd0;
  localparam logic [3:0] PH_STATUS  = 4'd1;
  localparam logic [3:0] PH_DATA1   = 4'd2;
  localparam logic [3:0] PH_DATA2   = 4'd3;
  localparam logic [3:0] PH_SYSLEN  = 4'd4;
  localparam logic [3:0] PH_SYSDATA = 4'd5;
  localparam logic [3:0] PH_MTYPE   = 4'd6;
  localparam logic [3:0] PH_MLEN    = 4'd7;
  localparam logic [3:0] PH_MDATA   = 4'd8;

  // ---------------------------------------------------------------------------
  // Configuration registers (APB, pready tied high)
  // ---------------------------------------------------------------------------
  logic [31:0] track_length_q;
  logic [15:0] sysex_max_len_q;
  logic [7:0]  meta_keep_len_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_length_q  <= TRACK_LENGTH_RST;
      sysex_max_len_q <= SYSEX_MAX_LEN_RST;
      meta_keep_len_q <= META_KEEP_LEN_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_TRACK_LENGTH:  track_length_q  <= pwdata;
        REG_SYSEX_MAX_LEN: sysex_max_len_q <= pwdata[15:0];
        REG_META_KEEP_LEN: meta_keep_len_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TRACK_LENGTH:  prdata = track_length_q;
      REG_SYSEX_MAX_LEN: prdata = {16'd0, sysex_max_len_q};
      REG_META_KEEP_LEN: prdata = {24'd0, meta_keep_len_q};
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds decode; decode writes the result register.
  // Decode proceeds whenever the result register is empty or being drained;
  // a new byte can enter the empty input register while a finished result still waits.
  // ---------------------------------------------------------------------------
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  logic      advance;
  logic      in_ready;
  logic      decode;
  logic      emit;
  out_item_t res;

  assign advance  = ~out_valid_q | event_o.ready;
  assign in_ready = ~in_valid_q | advance;
  assign decode   = in_valid_q & advance;
  assign byte_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && byte_i.valid) begin
      in_q.kind       <= byte_i.kind;
      in_q.byte_value <= byte_i.byte_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= decode & emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (decode && emit) begin
      out_q <= res;
    end
  end

  assign event_o.valid         = out_valid_q;
  assign event_o.event_kind    = out_q.event_kind;
  assign event_o.delta_ticks   = out_q.delta_ticks;
  assign event_o.status        = out_q.status;
  assign event_o.data1         = out_q.data1;
  assign event_o.data2         = out_q.data2;
  assign event_o.msg_bytes     = out_q.msg_bytes;
  assign event_o.meta_id       = out_q.meta_id;
  assign event_o.meta_length   = out_q.meta_length;
  assign event_o.payload_byte  = out_q.payload_byte;
  assign event_o.payload_valid = out_q.payload_valid;
  assign event_o.last          = out_q.last;
  assign event_o.tempo_us      = out_q.tempo_us;

  // ---------------------------------------------------------------------------
  // Parse state
  // pos_q counts payload bytes already read in the meta data phase; it
  // saturates, since only small positions (field bytes, kept bytes) matter.
  // ---------------------------------------------------------------------------
  logic [3:0]  phase_q, phase_d;
  logic [31:0] delta_acc_q, delta_acc_d;
  logic [7:0]  run_status_q, run_status_d;
  logic [1:0]  run_size_q, run_size_d;
  logic [7:0]  held_data_q, held_data_d;
  logic [31:0] byte_offset_q, byte_offset_d;
  logic [31:0] remaining_q, remaining_d;
  logic [7:0]  meta_kind_q, meta_kind_d;
  logic [23:0] field_acc_q, field_acc_d;
  logic        drop_q, drop_d;
  logic        ended_q, ended_d;
  logic [31:0] meta_len_q, meta_len_d;
  logic [8:0]  pos_q, pos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_DELTA;
      delta_acc_q   <= '0;
      run_status_q  <= '0;
      run_size_q    <= '0;
      held_data_q   <= '0;
      byte_offset_q <= '0;
      remaining_q   <= '0;
      meta_kind_q   <= '0;
      field_acc_q   <= '0;
      drop_q        <= 1'b0;
      ended_q       <= 1'b0;
      meta_len_q    <= '0;
      pos_q         <= '0;
    end else if (decode) begin
      phase_q       <= phase_d;
      delta_acc_q   <= delta_acc_d;
      run_status_q  <= run_status_d;
      run_size_q    <= run_size_d;
      held_data_q   <= held_data_d;
      byte_offset_q <= byte_offset_d;
      remaining_q   <= remaining_d;
      meta_kind_q   <= meta_kind_d;
      field_acc_q   <= field_acc_d;
      drop_q        <= drop_d;
      ended_q       <= ended_d;
      meta_len_q    <= meta_len_d;
      pos_q         <= pos_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode: one byte against the current phase
  // ---------------------------------------------------------------------------
  logic [7:0]  b;
  logic [31:0] rem_vlq;   // remaining with this byte's 7 bits shifted in
  logic [31:0] rem_dec;
  logic        rem_last;
  logic        finish;
  logic [23:0] acc_new;

  assign b        = in_q.byte_value;
  assign rem_vlq  = {remaining_q[24:0], b[6:0]};
  assign rem_dec  = remaining_q - 32'd1;
  assign rem_last = (rem_dec == 32'd0);
  assign acc_new  = {field_acc_q[15:0], b};

  always_comb begin
    phase_d       = phase_q;
    delta_acc_d   = delta_acc_q;
    run_status_d  = run_status_q;
    run_size_d    = run_size_q;
    held_data_d   = held_data_q;
    byte_offset_d = byte_offset_q;
    remaining_d   = remaining_q;
    meta_kind_d   = meta_kind_q;
    field_acc_d   = field_acc_q;
    drop_d        = drop_q;
    ended_d       = ended_q;
    meta_len_d    = meta_len_q;
    pos_d         = pos_q;
    finish        = 1'b0;
    emit          = 1'b0;
    res             = '0;
    res.delta_ticks = delta_acc_q;

    if (in_q.kind == KIND_RESTART) begin
      // running status and registers survive a restart
      phase_d       = PH_DELTA;
      delta_acc_d   = '0;
      held_data_d   = '0;
      byte_offset_d = '0;
      remaining_d   = '0;
      meta_kind_d   = '0;
      field_acc_d   = '0;
      drop_d        = 1'b0;
      ended_d       = 1'b0;
      meta_len_d    = '0;
      pos_d         = '0;
    end else if (!ended_q) begin
      byte_offset_d = byte_offset_q + 32'd1;
      case (phase_q)
        PH_DELTA: begin
          delta_acc_d = {delta_acc_q[24:0], b[6:0]};
          if (!b[7]) phase_d = PH_STATUS;
        end

        PH_STATUS: begin
          if (!b[7]) begin
            // data byte: running status, possibly none seen yet
            if (run_size_q == 2'd3) begin
              held_data_d = b;
              phase_d     = PH_DATA2;
            end else begin
              emit          = 1'b1;
              res.event_kind = EVT_CHANNEL;
              res.status    = run_status_q;
              res.data1     = b;
              res.msg_bytes = run_size_q;
              res.last      = 1'b1;
              finish        = 1'b1;
            end
          end else if (b[7:4] != 4'hF) begin
            run_status_d = b;
            run_size_d   = (b[7:5] == 3'b110) ? 2'd2 : 2'd3;
            phase_d      = PH_DATA1;
          end else if (b == ST_SYSEX || b == ST_SYSEX_CONT) begin
            meta_kind_d = b;
            remaining_d = '0;
            phase_d     = PH_SYSLEN;
          end else if (b == ST_META) begin
            phase_d = PH_MTYPE;
          end else begin
            // unknown system status: abort the track
            emit           = 1'b1;
            res.event_kind = EVT_ABORT;
            res.status     = b;
            res.last       = 1'b1;
            ended_d        = 1'b1;
            phase_d        = PH_DELTA;
          end
        end

        PH_DATA1: begin
          if (run_size_q == 2'd3) begin
            held_data_d = b;
            phase_d     = PH_DATA2;
          end else begin
            emit           = 1'b1;
            res.event_kind = EVT_CHANNEL;
            res.status     = run_status_q;
            res.data1      = b;
            res.msg_bytes  = run_size_q;
            res.last       = 1'b1;
            finish         = 1'b1;
          end
        end

        PH_DATA2: begin
          emit           = 1'b1;
          res.event_kind = EVT_CHANNEL;
          res.status     = run_status_q;
          res.data1      = held_data_q;
          res.data2      = b;
          res.msg_bytes  = run_size_q;
          res.last       = 1'b1;
          finish         = 1'b1;
        end

        PH_SYSLEN: begin
          remaining_d = rem_vlq;
          if (!b[7]) begin
            meta_len_d = rem_vlq;
            // size counts the F0 byte itself when the event starts with F0
            if (meta_kind_q == ST_SYSEX) drop_d = (rem_vlq >= {16'd0, sysex_max_len_q});
            else                         drop_d = (rem_vlq >  {16'd0, sysex_max_len_q});
            if (!drop_d) begin
              if (meta_kind_q == ST_SYSEX) begin
                emit              = 1'b1;
                res.event_kind    = EVT_SYSEX;
                res.status        = ST_SYSEX;
                res.meta_length   = rem_vlq;
                res.payload_byte  = ST_SYSEX;
                res.payload_valid = 1'b1;
                res.last          = (rem_vlq == 32'd0);
              end else if (rem_vlq == 32'd0) begin
                emit           = 1'b1;
                res.event_kind = EVT_SYSEX;
                res.status     = ST_SYSEX_CONT;
                res.last       = 1'b1;
              end
            end
            if (rem_vlq == 32'd0) finish  = 1'b1;
            else                  phase_d = PH_SYSDATA;
          end
        end

        PH_SYSDATA: begin
          remaining_d = rem_dec;
          if (!drop_q) begin
            emit              = 1'b1;
            res.event_kind    = EVT_SYSEX;
            res.status        = meta_kind_q;
            res.meta_length   = meta_len_q;
            res.payload_byte  = b;
            res.payload_valid = 1'b1;
            res.last          = rem_last;
          end
          if (rem_last) finish = 1'b1;
        end

        PH_MTYPE: begin
          meta_kind_d = b;
          remaining_d = '0;
          phase_d     = PH_MLEN;
        end

        PH_MLEN: begin
          remaining_d = rem_vlq;
          if (!b[7]) begin
            meta_len_d  = rem_vlq;
            field_acc_d = '0;
            held_data_d = '0;
            pos_d       = '0;
            if (meta_kind_q == META_EOT) begin
              // reported at the length byte; payload never read
              emit            = 1'b1;
              res.event_kind  = EVT_END;
              res.status      = ST_META;
              res.meta_id     = META_EOT;
              res.meta_length = rem_vlq;
              res.last        = 1'b1;
              ended_d         = 1'b1;
              phase_d         = PH_DELTA;
              delta_acc_d     = '0;
              remaining_d     = '0;
            end else begin
              if (meta_kind_q == META_TEMPO || meta_kind_q == META_TIMESIG) begin
                if (rem_vlq == 32'd0) begin
                  emit            = 1'b1;
                  res.event_kind  = (meta_kind_q == META_TEMPO) ? EVT_TEMPO : EVT_TIMESIG;
                  res.status      = ST_META;
                  res.meta_id     = meta_kind_q;
                  res.last        = 1'b1;
                end
              end else if (rem_vlq == 32'd0 || meta_keep_len_q == 8'd0) begin
                emit            = 1'b1;
                res.event_kind  = EVT_META;
                res.status      = ST_META;
                res.meta_id     = meta_kind_q;
                res.meta_length = rem_vlq;
                res.last        = 1'b1;
              end
              if (rem_vlq == 32'd0) finish  = 1'b1;
              else                  phase_d = PH_MDATA;
            end
          end
        end

        PH_MDATA: begin
          remaining_d = rem_dec;
          pos_d       = (pos_q == '1) ? pos_q : pos_q + 9'd1;
          if (meta_kind_q == META_TEMPO) begin
            if (pos_q < 9'd3) begin
              field_acc_d = acc_new;
              if (pos_q == 9'd2 || rem_last) begin
                // short tempo: missing low bytes read as zero
                emit            = 1'b1;
                res.event_kind  = EVT_TEMPO;
                res.status      = ST_META;
                res.meta_id     = META_TEMPO;
                res.meta_length = meta_len_q;
                res.last        = 1'b1;
                if (pos_q == 9'd0)      res.tempo_us = {acc_new[7:0], 16'd0};
                else if (pos_q == 9'd1) res.tempo_us = {acc_new[15:0], 8'd0};
                else                    res.tempo_us = acc_new;
              end
            end
          end else if (meta_kind_q == META_TIMESIG) begin
            if (pos_q == 9'd0) begin
              held_data_d = b;
              if (rem_last) begin
                emit            = 1'b1;
                res.event_kind  = EVT_TIMESIG;
                res.status      = ST_META;
                res.meta_id     = META_TIMESIG;
                res.meta_length = meta_len_q;
                res.data1       = b;
                res.last        = 1'b1;
              end
            end else if (pos_q == 9'd1) begin
              emit            = 1'b1;
              res.event_kind  = EVT_TIMESIG;
              res.status      = ST_META;
              res.meta_id     = META_TIMESIG;
              res.meta_length = meta_len_q;
              res.data1       = held_data_q;
              res.data2       = b;
              res.last        = 1'b1;
            end
          end else if (pos_q < {1'b0, meta_keep_len_q}) begin
            // kept bytes end at the keep limit or at the end of the payload
            emit              = 1'b1;
            res.event_kind    = EVT_META;
            res.status        = ST_META;
            res.meta_id       = meta_kind_q;
            res.meta_length   = meta_len_q;
            res.payload_byte  = b;
            res.payload_valid = 1'b1;
            res.last          = (pos_q + 9'd1 == {1'b0, meta_keep_len_q}) || rem_last;
          end
          if (rem_last) finish = 1'b1;
        end

        default: phase_d = PH_DELTA;
      endcase

      if (finish) begin
        phase_d     = PH_DELTA;
        delta_acc_d = '0;
        remaining_d = '0;
        if (byte_offset_d >= track_length_q) ended_d = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/mtep_checker.sv =====
// Port-level checks for the MIDI track event parser, bound to the top level.
// Depends on mtep_pkg and midi_track_event_parser.
`default_nettype none

module mtep_checker
  import mtep_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] event_kind,
  input wire logic [7:0] payload_byte,
  input wire logic       payload_valid,
  input wire logic       last,
  input wire logic [7:0] status
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result payload holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(payload_byte) && $stable(event_kind) && $stable(last))
    else $error("result payload changed while stalled");

  // only sysex and meta payload events carry a byte
  a_payload_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && payload_valid |-> (event_kind == EVT_SYSEX || event_kind == EVT_META))
    else $error("payload byte on a non-payload event");

  // tempo, time signature and end events always close their event and report status FF
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (event_kind == EVT_TEMPO || event_kind == EVT_TIMESIG ||
                  event_kind == EVT_END)
    |-> last && status == ST_META)
    else $error("decoded meta result malformed");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (event_o.valid),
  .out_ready     (event_o.ready),
  .event_kind    (event_o.event_kind),
  .payload_byte  (event_o.payload_byte),
  .payload_valid (event_o.payload_valid),
  .last          (event_o.last),
  .status        (event_o.status)
);

`default_nettype wire
